### sv/spq_pkg.sv
// Package: shared constants and types of the sorted priority queue.
package spq_pkg;

	localparam int CNT_W     = 5;
	localparam int CAP_W     = 5;
	localparam int ST_W      = 2;
	localparam int CAP_MAX   = (1 << CAP_W) - 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Broadcast control seen by one cell of the sorted chain.
	typedef struct packed {
		logic ins;     // insert taking effect this cycle
		logic occ;     // cell lies below the current count
		logic at_end;  // cell is the first free slot
	} cell_ctl_t;

endpackage

### sv/spq_ifs.sv
// Interfaces: request, result and configuration channels of the queue.
interface spq_req_if #(parameter int VW = 32);
	logic          valid;
	logic          ready;
	logic          mode;
	logic [VW-1:0] value;

	modport source (output valid, mode, value, input ready);
	modport sink   (input valid, mode, value, output ready);
endinterface

interface spq_rsp_if #(parameter int VW = 32);
	logic                         valid;
	logic                         ready;
	logic [spq_pkg::ST_W-1:0]     status;
	logic [VW-1:0]                front_value;
	logic                         front_valid;
	logic [spq_pkg::CNT_W-1:0]    entry_count;
	logic                         is_full;
	logic                         is_empty;

	modport source (output valid, status, front_value, front_valid, entry_count, is_full,
		is_empty, input ready);
	modport sink   (input valid, status, front_value, front_valid, entry_count, is_full,
		is_empty, output ready);
endinterface

interface spq_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [spq_pkg::CAP_W-1:0] capacity_in_use;

	modport source (output valid, capacity_in_use, input ready);
	modport sink   (input valid, capacity_in_use, output ready);
endinterface

### sv/spq_cell.sv
// One cell of the sorted chain: holds one entry, shifts up from its lower neighbor.
module spq_cell #(
	parameter int VW = 32
) (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic [VW-1:0]      ins_value,
	input  logic [VW-1:0]      left_value,
	input  logic               left_ge,
	output logic [VW-1:0]      value,
	output logic               ge
);
	import spq_pkg::*;

	logic [VW-1:0] val_q;

	// ge: this entry moves up when the new value lands at or below it
	assign ge    = ctl.occ && ($signed(ins_value) <= $signed(val_q));
	assign value = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && ((ctl.occ && ge) || ctl.at_end)) begin
			val_q <= left_ge ? left_value : ins_value;
		end
	end

endmodule

### sv/sorted_priority_queue_core.sv
// Top level: bounded max-priority queue kept in a sorted chain of cells.
//
// Usage:
//   req carries one item per handshake: mode 0 inserts value, mode 1 removes the
//   largest entry. rsp returns exactly one result per request item: status, the
//   front (largest) entry with its valid bit, the entry count and full/empty flags,
//   all describing the queue after the operation.
//   cfg writes capacity_in_use (values above MAX_ENTRIES act as MAX_ENTRIES,
//   zero makes every insert drop); always ready; the user must write it only while idle.
// Timing and throughput:
//   A result is loaded into the rsp register when its item is accepted.
//   One item per cycle unless rsp stalls: every cell compares against the new value
//   and shifts in the same cycle; the front is read from the chain at the count.
// Stall:
//   req.ready drops while a result waits in rsp and rsp.ready is low; nothing is
//   lost or repeated.
// Reset:
//   arst_n clears the count and the output valid and loads capacity 10; the cell
//   contents stay undefined and are read only below the count.
module sorted_priority_queue_core #(
	parameter int MAX_ENTRIES = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp,
	spq_cfg_if.sink    cfg
);
	import spq_pkg::*;

	localparam int CAP_LIM = (MAX_ENTRIES > CAP_MAX) ? CAP_MAX : MAX_ENTRIES;

	logic [CAP_W-1:0]       cap_q;
	logic [CNT_W-1:0]       count_q;
	logic [CAP_W-1:0]       cap_eff;

	logic [VALUE_WIDTH-1:0] vals [MAX_ENTRIES];
	logic                   ges  [MAX_ENTRIES];
	logic [VALUE_WIDTH-1:0] top_val;
	logic [VALUE_WIDTH-1:0] sec_val;

	logic                   acc;
	logic                   ins;
	logic [CNT_W-1:0]       cnt_n;
	logic [ST_W-1:0]        st_n;
	logic [VALUE_WIDTH-1:0] front_n;
	logic                   fv_n;

	logic                   out_valid_q;
	logic [ST_W-1:0]        status_q;
	logic [VALUE_WIDTH-1:0] front_q;
	logic                   fv_q;
	logic [CNT_W-1:0]       count_out_q;
	logic                   full_q;
	logic                   empty_q;

	assign cap_eff   = (cap_q > CAP_W'(CAP_LIM)) ? CAP_W'(CAP_LIM) : cap_q;
	assign req.ready = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign acc       = req.valid && req.ready;
	assign ins       = acc && (req.mode == MODE_INSERT) && (count_q < cap_eff);

	// front and the entry just below it, read at the count
	always_comb begin
		top_val = '0;
		sec_val = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (i == int'(count_q) - 1) top_val = vals[i];
			if (i == int'(count_q) - 2) sec_val = vals[i];
		end
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_ctl_t              ctl;
		logic [VALUE_WIDTH-1:0] lv;
		logic                   lg;

		assign ctl.ins    = ins;
		assign ctl.occ    = (i < int'(count_q));
		assign ctl.at_end = (i == int'(count_q));

		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_rest
			assign lv = vals[i-1];
			assign lg = ges[i-1];
		end

		spq_cell #(.VW(VALUE_WIDTH)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.ins_value  (req.value),
			.left_value (lv),
			.left_ge    (lg),
			.value      (vals[i]),
			.ge         (ges[i])
		);
	end

	always_comb begin
		cnt_n   = count_q;
		st_n    = ST_DONE;
		front_n = top_val;
		fv_n    = (count_q != '0);
		if (req.mode == MODE_INSERT) begin
			if (count_q >= cap_eff) begin
				st_n = ST_FULL;
			end else begin
				cnt_n = count_q + CNT_W'(1);
				fv_n  = 1'b1;
				if (count_q == '0 || $signed(req.value) > $signed(top_val)) begin
					front_n = req.value;
				end
			end
		end else begin
			if (count_q == '0) begin
				st_n = ST_EMPTY;
			end else begin
				cnt_n   = count_q - CNT_W'(1);
				fv_n    = (count_q >= CNT_W'(2));
				front_n = fv_n ? sec_val : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.capacity_in_use;
			end
			if (acc) begin
				count_q     <= cnt_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q    <= st_n;
			front_q     <= front_n;
			fv_q        <= fv_n;
			count_out_q <= cnt_n;
			full_q      <= (cnt_n >= cap_eff);
			empty_q     <= (cnt_n == '0);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.front_value = front_q;
	assign rsp.front_valid = fv_q;
	assign rsp.entry_count = count_out_q;
	assign rsp.is_full     = full_q;
	assign rsp.is_empty    = empty_q;

endmodule

### sv/spq_chk.sv
// Checker: port-level assertions on the queue results, bound to the top level.
module spq_chk #(
	parameter int VW = 32
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      o_valid,
	input logic                      o_ready,
	input logic [spq_pkg::ST_W-1:0]  o_status,
	input logic [VW-1:0]             o_front,
	input logic                      o_fv,
	input logic [spq_pkg::CNT_W-1:0] o_count,
	input logic                      o_empty
);
	import spq_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> (o_status == ST_DONE || o_status == ST_FULL || o_status == ST_EMPTY))
		else $error("result status code out of range");

	a_empty_flags: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> (o_empty == (o_count == '0)) && (o_fv == !o_empty))
		else $error("empty flag, count and front valid disagree");

	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid && !o_fv) |-> (o_front == '0))
		else $error("front value not zero on empty queue");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid && !o_ready) |=> (o_valid && $stable(o_front) && $stable(o_count)
			&& $stable(o_status)))
		else $error("stalled result changed");

endmodule

bind sorted_priority_queue_core spq_chk #(.VW(VALUE_WIDTH)) u_spq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.o_valid  (rsp.valid),
	.o_ready  (rsp.ready),
	.o_status (rsp.status),
	.o_front  (rsp.front_value),
	.o_fv     (rsp.front_valid),
	.o_count  (rsp.entry_count),
	.o_empty  (rsp.is_empty)
);
